FILE: rtl/olar_pkg.sv
package olar_pkg;

  // Default list capacity
  localparam int DEF_CAPACITY = 16;

  // Payload widths
  localparam int VAL_W    = 32;
  localparam int ACT_W    = 2;
  localparam int STATUS_W = 2;

  // Action codes; code three is unused and ignored
  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LIST   = 2'd2
  } action_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_ROT
  } state_t;

  // Controls broadcast along the cell chain
  typedef struct packed {
    logic load;   // write the append value at the tail slot
    logic shift;  // every cell takes its right neighbor
    logic wrap;   // last used slot takes the head value instead
  } chain_ctl_t;

endpackage

FILE: rtl/olar_if.sv
interface olar_in_if;
  import olar_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface olar_out_if;
  import olar_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] entry;
  logic [STATUS_W-1:0]     status;
  logic                    is_last;

  modport source (output valid, output entry, output status, output is_last, input ready);
  modport sink   (input valid, input entry, input status, input is_last, output ready);
endinterface

FILE: rtl/olar_cell.sv
module olar_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                              clk,
  input  olar_pkg::chain_ctl_t              ctl,
  input  logic [CNT_W-1:0]                  count,
  input  logic signed [olar_pkg::VAL_W-1:0] load_val,
  input  logic signed [olar_pkg::VAL_W-1:0] right_in,
  input  logic signed [olar_pkg::VAL_W-1:0] head_in,
  output logic signed [olar_pkg::VAL_W-1:0] data_o
);
  import olar_pkg::*;

  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] data_nxt;
  logic                    is_tail_slot;
  logic                    is_last_used;

  // Decode this cell's position against the fill count
  assign is_tail_slot = (count == CNT_W'(IDX));
  assign is_last_used = ((count - CNT_W'(1)) == CNT_W'(IDX));

  // Load on append, wrap the head into the last used slot, else advance
  always_comb begin
    data_nxt = data_r;
    if (ctl.load && is_tail_slot) begin
      data_nxt = load_val;
    end else if (ctl.shift) begin
      if (ctl.wrap && is_last_used) begin
        data_nxt = head_in;
      end else begin
        data_nxt = right_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

FILE: rtl/olar_ctrl.sv
module olar_ctrl #(
  parameter int CAPACITY = olar_pkg::DEF_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  olar_in_if.sink                           in_ch,
  olar_out_if.source                        out_ch,
  input  logic signed [olar_pkg::VAL_W-1:0] head,
  output olar_pkg::chain_ctl_t              ctl,
  output logic [CNT_W-1:0]                  count
);
  import olar_pkg::*;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        steps_r, steps_nxt;
  logic                    is_remove_r, is_remove_nxt;
  logic                    found_r, found_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] entry_r, entry_nxt;
  status_t                 status_r, status_nxt;
  logic                    last_r, last_nxt;

  logic                    slot_free;
  logic                    accept;
  logic                    hit;
  logic                    final_step;
  action_t                 act;

  assign slot_free  = !out_valid_r || out_ch.ready;
  assign accept     = in_ch.valid && slot_free && (state_r == ST_IDLE);
  assign act        = action_t'(in_ch.action);
  assign hit        = is_remove_r && !found_r && (head == value_r);
  assign final_step = (steps_r == CNT_W'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && count_r != '0 && (act == ACT_REMOVE || act == ACT_LIST)) begin
          state_nxt = ST_ROT;
        end
      end
      ST_ROT: begin
        if (slot_free && final_step) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs, chain controls and datapath registers
  always_comb begin
    in_ch.ready   = 1'b0;
    ctl           = '0;
    count_nxt     = count_r;
    steps_nxt     = steps_r;
    is_remove_nxt = is_remove_r;
    found_nxt     = found_r;
    value_nxt     = value_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    entry_nxt     = entry_r;
    status_nxt    = status_r;
    last_nxt      = last_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = slot_free;
        if (accept) begin
          value_nxt  = in_ch.value;
          steps_nxt  = count_r;
          found_nxt  = 1'b0;
          entry_nxt  = '0;
          last_nxt   = 1'b1;
          case (act)
            ACT_APPEND: begin
              out_valid_nxt = 1'b1;
              if (count_r == CNT_W'(CAPACITY)) begin
                status_nxt = STAT_FULL;
              end else begin
                ctl.load   = 1'b1;
                count_nxt  = count_r + CNT_W'(1);
                status_nxt = STAT_OK;
              end
            end
            ACT_REMOVE: begin
              is_remove_nxt = 1'b1;
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                status_nxt    = STAT_NOT_FOUND;
              end
            end
            ACT_LIST: begin
              is_remove_nxt = 1'b0;
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                status_nxt    = STAT_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ROT: begin
        if (slot_free) begin
          // Rotate the ring by one; drop the head on the first match
          ctl.shift = 1'b1;
          ctl.wrap  = !hit;
          steps_nxt = steps_r - CNT_W'(1);
          if (hit) begin
            found_nxt = 1'b1;
            count_nxt = count_r - CNT_W'(1);
          end
          if (is_remove_r) begin
            if (final_step) begin
              out_valid_nxt = 1'b1;
              entry_nxt     = '0;
              status_nxt    = (found_r || hit) ? STAT_OK : STAT_NOT_FOUND;
              last_nxt      = 1'b1;
            end
          end else begin
            out_valid_nxt = 1'b1;
            entry_nxt     = head;
            status_nxt    = STAT_OK;
            last_nxt      = final_step;
          end
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and operation registers
  always_ff @(posedge clk) begin
    steps_r     <= steps_nxt;
    is_remove_r <= is_remove_nxt;
    found_r     <= found_nxt;
    value_r     <= value_nxt;
    entry_r     <= entry_nxt;
    status_r    <= status_nxt;
    last_r      <= last_nxt;
  end

  assign count          = count_r;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.entry   = entry_r;
  assign out_ch.status  = status_r;
  assign out_ch.is_last = last_r;

endmodule

FILE: rtl/ordered_list_append_remove_top.sv
// Ordered list of signed 32-bit values, up to CAPACITY entries.
// Input channel in_ch carries an action and a value; a transfer happens when
// valid and ready are both high. Result channel out_ch carries entry, status
// and is_last from an output register.
// Append: one result, registered in the cycle after the transfer (ok or full).
// Remove: the stored entries rotate through a chain of cells, one position
// per cycle unless stalled, with the head compared and dropped on the first
// match; the single result follows the last rotation step, and the next item
// is taken after that. Remove on an empty list answers in the next cycle.
// List: the same rotation emits the head each cycle, so count results leave
// at one per cycle unless stalled, the first after the rotate state and then
// the output register, the tail marked by is_last. An empty list gives one
// empty-status result. Action code three is dropped without a result.
// Remove and list take no new item until the ring rotation ends.
// Reset clears the fill count and the output valid; the cells need no clear.
// A stalled receiver holds the output register and freezes the rotation;
// no result is lost or repeated.
module ordered_list_append_remove_top #(
  parameter int CAPACITY = olar_pkg::DEF_CAPACITY
) (
  input  logic       clk,
  input  logic       rst_n,
  olar_in_if.sink    in_ch,
  olar_out_if.source out_ch
);
  import olar_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  chain_ctl_t              ctl;
  logic [CNT_W-1:0]        count;
  logic signed [VAL_W-1:0] cell_data [CAPACITY];

  // Sequence append, rotate, emit
  olar_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .head   (cell_data[0]),
    .ctl    (ctl),
    .count  (count)
  );

  // Chain of storage cells, head at cell zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int RIGHT = (i + 1 < CAPACITY) ? i + 1 : i;
    olar_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (count),
      .load_val (in_ch.value),
      .right_in (cell_data[RIGHT]),
      .head_in  (cell_data[0]),
      .data_o   (cell_data[i])
    );
  end

endmodule
